// ===== sv/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg: sliding median filter shared definitions
// defaults, widths and the control group of the sorting chain
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_WINDOW_DEF  = 31;

	localparam int CFG_W        = 5;
	localparam int WINDOW_RESET = 5;
	localparam int AGE_W        = 6;
	localparam int EDGE_W       = 5;
	localparam int SEEN_MAX     = 63;

	typedef struct packed {
		logic clear;
		logic insert;
	} smf_chain_ctl_t;

endpackage

// ===== sv/smf_if.sv =====
// ----------------------------------------------------------------------------
// smf_if: sliding median filter stream channels
// sample channel into the filter and result channel out of it
// ----------------------------------------------------------------------------
interface smf_sample_if #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface smf_result_if #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          end_of_array;

	modport source (output valid, output filtered, output end_of_array, input ready);
	modport sink   (input valid, input filtered, input end_of_array, output ready);
endinterface

// ===== sv/sliding_median_filter_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_median_filter_unit: running median filter, odd window
// replaces interior samples of an array by the median of their centered window
// ----------------------------------------------------------------------------
// channel     | dir | payload                 | beat when
// sample_ch   | in  | sample, last            | valid && ready
// result_ch   | out | filtered, end_of_array  | valid && ready
// cfg_wr_*    | in  | window_size             | cfg_wr_en
//
// the next input beat is not taken until the results the last one released have been sent
// a passed-through result is read from the sample history; a median result is formed
// by inserting the W window samples one per cycle into the cell chain
// one sample is taken at a time; ready stays low while results are pending
// a stalled result holds in the output register; no clearing pass after reset
// ----------------------------------------------------------------------------
module sliding_median_filter_unit #(
	parameter int MAX_WINDOW  = smf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [smf_pkg::CFG_W-1:0] cfg_wr_data,
	smf_sample_if.sink                sample_ch,
	smf_result_if.source              result_ch
);
	import smf_pkg::*;

	localparam int IDX_W   = $clog2(MAX_WINDOW);
	localparam int WIN_CAP = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
	localparam int H_MAX   = ((WIN_CAP < 31) ? WIN_CAP : 31) / 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_FEED,
		ST_SETTLE,
		ST_OUT
	} state_t;

	state_t                        state_q;
	logic [CFG_W-1:0]              cfg_q;
	logic [AGE_W-1:0]              h_q;
	logic [AGE_W-1:0]              t_q;
	logic [AGE_W-1:0]              pend_q;
	logic [AGE_W-1:0]              feed_q;
	logic [AGE_W-1:0]              seen_q;
	logic [EDGE_W-1:0]             edge_q;
	logic                          last_q;
	logic                          done_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_end_q;
	logic signed [SAMPLE_BITS-1:0] hist_q[MAX_WINDOW];

	logic [AGE_W-1:0]              w_eff;
	logic [AGE_W-1:0]              h_new;
	logic [AGE_W-1:0]              off;
	logic [AGE_W-1:0]              rd_age;
	logic signed [SAMPLE_BITS-1:0] hist_rd;
	logic signed [SAMPLE_BITS-1:0] median;
	logic                          emit_now;
	logic                          filt;
	logic                          take;
	smf_chain_ctl_t                chain_ctl;

	// effective window length
	always_comb begin
		w_eff = {{(AGE_W-CFG_W){1'b0}}, cfg_q};
		if (w_eff == '0) begin
			w_eff = AGE_W'(1);
		end
		if (!w_eff[0]) begin
			w_eff = w_eff - AGE_W'(1);
		end
		if (w_eff > AGE_W'(WIN_CAP)) begin
			w_eff = AGE_W'(WIN_CAP);
		end
		h_new = w_eff >> 1;
	end

	assign take     = sample_ch.valid && sample_ch.ready;
	assign off      = pend_q - AGE_W'(1);
	assign emit_now = ((pend_q > h_q) && !done_q) || (last_q && (pend_q != '0));
	assign filt     = (off >= h_q) && (t_q >= off) && ((t_q - off) >= h_q);
	assign rd_age   = (state_q == ST_FEED) ? (off - h_q + feed_q) : off;
	assign hist_rd  = (rd_age < AGE_W'(MAX_WINDOW)) ? hist_q[rd_age[IDX_W-1:0]] : '0;

	assign chain_ctl.clear  = (state_q == ST_NEXT);
	assign chain_ctl.insert = (state_q == ST_FEED);

	smf_sort_chain #(
		.DEPTH      (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (chain_ctl),
		.ins_value(hist_rd),
		.sel      (h_q[IDX_W-1:0]),
		.sel_value(median)
	);

	assign sample_ch.ready        = (state_q == ST_IDLE);
	assign result_ch.valid        = out_valid_q;
	assign result_ch.filtered     = out_data_q;
	assign result_ch.end_of_array = out_end_q;

	// sample history, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else if (take) begin
			hist_q[0] <= sample_ch.sample;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(WINDOW_RESET);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= '0;
			t_q         <= '0;
			pend_q      <= '0;
			feed_q      <= '0;
			seen_q      <= '0;
			edge_q      <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						h_q     <= h_new;
						t_q     <= seen_q;
						pend_q  <= {1'b0, edge_q} + AGE_W'(1);
						last_q  <= sample_ch.last;
						done_q  <= 1'b0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (emit_now) begin
						if (filt) begin
							feed_q  <= '0;
							state_q <= ST_FEED;
						end else begin
							out_data_q  <= hist_rd;
							out_end_q   <= last_q && (pend_q == AGE_W'(1));
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end
					end else begin
						if (last_q) begin
							edge_q <= '0;
							seen_q <= '0;
						end else begin
							edge_q <= pend_q[EDGE_W-1:0];
							seen_q <= (t_q == AGE_W'(SEEN_MAX)) ? t_q : t_q + AGE_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FEED: begin
					feed_q <= feed_q + AGE_W'(1);
					if (feed_q == (h_q << 1)) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					out_data_q  <= median;
					out_end_q   <= last_q && (pend_q == AGE_W'(1));
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (result_ch.ready) begin
						out_valid_q <= 1'b0;
						pend_q      <= off;
						done_q      <= 1'b1;
						state_q     <= ST_NEXT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// no sample is taken while a result is still pending
	a_no_take_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_ch.ready && result_ch.valid))
		else $error("sample taken while a result is pending");

	// pending positions never exceed the largest half window
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_q <= EDGE_W'(H_MAX))
		else $error("pending position count out of range");

	// window feed stays inside the sample history
	a_feed_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FEED) |-> (rd_age < AGE_W'(MAX_WINDOW)))
		else $error("window feed beyond history");

	// a result beat is followed by the next decision step
	a_beat_then_next: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.ready) |=> (state_q == ST_NEXT && !result_ch.valid))
		else $error("result beat not followed by decision step");

endmodule

// ===== sv/smf_cell.sv =====
// ----------------------------------------------------------------------------
// smf_cell: one cell of the insertion sorting chain
// holds one sorted entry; takes the new value or its left neighbor's entry
// ----------------------------------------------------------------------------
module smf_cell #(
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smf_pkg::smf_chain_ctl_t       ctl,
	input  logic signed [SAMPLE_BITS-1:0] ins_value,
	input  logic                          left_ins_first,
	input  logic signed [SAMPLE_BITS-1:0] left_value,
	input  logic                          left_valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic                          valid,
	output logic                          ins_first
);
	import smf_pkg::*;

	logic signed [SAMPLE_BITS-1:0] value_q;
	logic                          valid_q;

	assign ins_first = !valid_q || (ins_value < value_q);
	assign value     = value_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			if (left_ins_first) begin
				valid_q <= left_valid;
			end else if (ins_first) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && !ctl.clear) begin
			if (left_ins_first) begin
				value_q <= left_value;
			end else if (ins_first) begin
				value_q <= ins_value;
			end
		end
	end

endmodule

// ===== sv/smf_sort_chain.sv =====
// ----------------------------------------------------------------------------
// smf_sort_chain: row of sorting cells
// keeps the inserted values in ascending order, one insert per cycle
// ----------------------------------------------------------------------------
module smf_sort_chain #(
	parameter int DEPTH       = smf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W      = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smf_pkg::smf_chain_ctl_t       ctl,
	input  logic signed [SAMPLE_BITS-1:0] ins_value,
	input  logic [IDX_W-1:0]              sel,
	output logic signed [SAMPLE_BITS-1:0] sel_value
);
	import smf_pkg::*;

	logic signed [SAMPLE_BITS-1:0] vals   [DEPTH];
	logic                          valids [DEPTH];
	logic                          befores[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                          l_before;
		logic signed [SAMPLE_BITS-1:0] l_value;
		logic                          l_valid;

		if (i == 0) begin : g_head
			assign l_before = 1'b0;
			assign l_value  = '0;
			assign l_valid  = 1'b0;
		end else begin : g_body
			assign l_before = befores[i-1];
			assign l_value  = vals[i-1];
			assign l_valid  = valids[i-1];
		end

		smf_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl),
			.ins_value     (ins_value),
			.left_ins_first(l_before),
			.left_value    (l_value),
			.left_valid    (l_valid),
			.value         (vals[i]),
			.valid         (valids[i]),
			.ins_first     (befores[i])
		);
	end

	assign sel_value = vals[sel];

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: sliding median filter testbench
// sends arrays of range samples with idle gaps on both channels, rewrites the
// window length between and inside arrays, and checks every result beat
// against a median predictor kept in the bench
// ----------------------------------------------------------------------------
module tb;
	import smf_pkg::*;

	localparam int SB         = SAMPLE_BITS_DEF;
	localparam int MW         = MAX_WINDOW_DEF;
	localparam int RAND_ITEMS = 260;
	localparam int SETTLE     = 48;
	localparam int LIMIT      = 1000000;
	localparam int N_ROWS     = 30;
	localparam int LOW_IDLE   = 14;
	localparam int HIGH_IDLE  = 73;

	typedef logic signed [SB-1:0] sample_t;

	typedef enum int {SLOW_SINK, SLOW_SOURCE, NO_IDLE} idle_phase_t;

	typedef struct packed {
		sample_t filtered;
		logic    end_of_array;
	} result_beat_t;

	typedef struct packed {
		logic             is_cfg;
		logic [CFG_W-1:0] win;
		sample_t          smp;
		logic             lst;
		logic             typed;
		sample_t          want;
		logic             want_eoa;
	} stim_row_t;

	// cfg rows: is_cfg, win; sample rows: smp, lst, and a typed beat where obvious
	stim_row_t directed_rows [N_ROWS] = '{
		'{1'b0, 5'd0,  16'sd100,    1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  -16'sd200,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd300,    1'b1, 1'b0, 16'sd0,      1'b0},
		'{1'b1, 5'd0,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sh7fff,   1'b0, 1'b1, 16'sh7fff,   1'b0},
		'{1'b0, 5'd0,  16'sh8000,   1'b0, 1'b1, 16'sh8000,   1'b0},
		'{1'b0, 5'd0,  16'sh5555,   1'b1, 1'b1, 16'sh5555,   1'b1},
		'{1'b0, 5'd0,  16'shffff,   1'b1, 1'b1, 16'shffff,   1'b1},
		'{1'b1, 5'd31, 16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  -16'sd5,     1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd7,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd3,      1'b1, 1'b0, 16'sd0,      1'b0},
		'{1'b1, 5'd4,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sh7fff,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sh8000,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd1,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'shffff,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sh7fff,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sh8000,   1'b1, 1'b0, 16'sd0,      1'b0},
		'{1'b1, 5'd7,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd10,     1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  -16'sd20,    1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd30,     1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  -16'sd40,    1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b1, 5'd3,  16'sd0,      1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd50,     1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  -16'sd60,    1'b0, 1'b0, 16'sd0,      1'b0},
		'{1'b0, 5'd0,  16'sd70,     1'b1, 1'b0, 16'sd0,      1'b0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	smf_sample_if sample_ch ();
	smf_result_if result_ch ();

	sliding_median_filter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample_ch   (sample_ch),
		.result_ch   (result_ch)
	);

	// predictor state
	sample_t          sample_hist [MW];
	int unsigned      seen_count;
	int unsigned      held_positions;
	logic [CFG_W-1:0] window_reg;
	result_beat_t     step_beats [$];
	result_beat_t     expected_beats [$];
	result_beat_t     front_beat;

	int mismatches    = 0;
	int beats_checked = 0;
	int arrays_sent   = 0;
	int samples_sent  = 0;
	int window_writes = 0;
	int cycle_count   = 0;
	int send_idle     = 0;
	int recv_idle     = 0;

	always #2 clk = ~clk;

	function automatic int unsigned window_len();
		int unsigned w;
		w = window_reg;
		if (w == 0) w = 1;
		if (w % 2 == 0) w = w - 1;
		if (w > MW) w = MW;
		return w;
	endfunction

	function automatic sample_t window_median(int unsigned pos, int unsigned h);
		sample_t vals [MW];
		sample_t v;
		int      i;
		int      k;
		for (i = 0; i <= 2 * h; i++) begin
			v = sample_hist[pos - h + i];
			k = i;
			while (k > 0 && vals[k-1] > v) begin
				vals[k] = vals[k-1];
				k--;
			end
			vals[k] = v;
		end
		return vals[h];
	endfunction

	function automatic void release_position(int unsigned pos, int unsigned seen,
	                                         int unsigned h);
		result_beat_t b;
		if (pos >= h && seen >= pos && seen - pos >= h) b.filtered = window_median(pos, h);
		else b.filtered = sample_hist[pos];
		b.end_of_array = 1'b0;
		step_beats.push_back(b);
	endfunction

	function automatic void predict_filter_step(sample_t smp, logic lst);
		int unsigned  h;
		int unsigned  seen;
		int unsigned  pend;
		int           i;
		result_beat_t b;
		h    = window_len() / 2;
		seen = seen_count;
		pend = held_positions + 1;
		step_beats.delete();
		for (i = MW - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
		sample_hist[0] = smp;
		if (pend > h) begin
			release_position(pend - 1, seen, h);
			pend--;
		end
		if (lst) begin
			while (pend > 0) begin
				release_position(pend - 1, seen, h);
				pend--;
			end
			b = step_beats.pop_back();
			b.end_of_array = 1'b1;
			step_beats.push_back(b);
			seen_count     = 0;
			held_positions = 0;
		end else begin
			held_positions = pend % 32;
			seen_count     = (seen + 1 > SEEN_MAX) ? SEEN_MAX : seen + 1;
		end
	endfunction

	function automatic sample_t random_sample();
		// narrow values give ties inside the window
		if ($urandom_range(3) == 0) return sample_t'(int'($urandom_range(8)) - 4);
		return sample_t'($urandom_range(16'hffff));
	endfunction

	function automatic logic [CFG_W-1:0] random_window();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 5'd30;
			default: return CFG_W'($urandom_range(31));
		endcase
	endfunction

	function automatic void set_idle(idle_phase_t ph);
		case (ph)
			SLOW_SINK: begin
				send_idle = LOW_IDLE;
				recv_idle = HIGH_IDLE;
			end
			SLOW_SOURCE: begin
				send_idle = HIGH_IDLE;
				recv_idle = LOW_IDLE;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endfunction

	task automatic send_sample(sample_t smp, logic lst, logic typed = 1'b0,
	                           result_beat_t want = '0);
		while ($urandom_range(99) < send_idle) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= smp;
		sample_ch.last   <= lst;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		predict_filter_step(smp, lst);
		if (typed) expected_beats.push_back(want);
		else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
		samples_sent++;
		if (lst) arrays_sent++;
		@(negedge clk);
	endtask

	task automatic drain_filter();
		int n;
		sample_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_beats.size() != 0) @(negedge clk);
		for (n = 0; n < SETTLE; n++) @(negedge clk);
	endtask

	task automatic write_window(logic [CFG_W-1:0] w);
		drain_filter();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		window_reg = w;
		window_writes++;
	endtask

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual filtered %0d eoa %0b",
				         $time, result_ch.filtered, result_ch.end_of_array);
				mismatches++;
			end else begin
				front_beat = expected_beats.pop_front();
				beats_checked++;
				if (result_ch.filtered !== front_beat.filtered) begin
					$display("%0t filtered mismatch: expected %0d actual %0d",
					         $time, front_beat.filtered, result_ch.filtered);
					mismatches++;
				end
				if (result_ch.end_of_array !== front_beat.end_of_array) begin
					$display("%0t end_of_array mismatch: expected %0b actual %0b",
					         $time, front_beat.end_of_array, result_ch.end_of_array);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("%0t timeout with %0d beats outstanding", $time, expected_beats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int           r;
		int           k;
		int           len;
		int           left;
		idle_phase_t  phase;
		stim_row_t    row;
		result_beat_t typed_beat;

		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		sample_ch.last   = 1'b0;
		result_ch.ready  = 1'b0;
		foreach (sample_hist[i]) sample_hist[i] = '0;
		seen_count     = 0;
		held_positions = 0;
		window_reg     = WINDOW_RESET;
		phase          = SLOW_SINK;
		set_idle(phase);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < N_ROWS; r++) begin
			row = directed_rows[r];
			if (row.is_cfg) begin
				write_window(row.win);
			end else begin
				typed_beat = '{row.want, row.want_eoa};
				send_sample(row.smp, row.lst, row.typed, typed_beat);
			end
		end

		left = RAND_ITEMS;
		while (left > 0) begin
			if (phase == SLOW_SINK && left <= 2 * RAND_ITEMS / 3) begin
				phase = SLOW_SOURCE;
				set_idle(phase);
			end else if (phase == SLOW_SOURCE && left <= RAND_ITEMS / 3) begin
				phase = NO_IDLE;
				set_idle(phase);
			end
			// now and then a long array at the widest window to saturate the sample count
			if (arrays_sent % 12 == 5) begin
				len = $urandom_range(64, 72);
				write_window(5'd31);
			end else begin
				len = $urandom_range(1, 36);
				if ($urandom_range(2) == 0) write_window(random_window());
			end
			if (len > left) len = left;
			for (k = 0; k < len; k++) begin
				if (k > 0 && $urandom_range(39) == 0) write_window(random_window());
				send_sample(random_sample(), k == len - 1);
				left--;
			end
		end

		drain_filter();
		$display("ran %0d arrays, %0d samples, %0d result beats checked",
		         arrays_sent, samples_sent, beats_checked);
		$display("%0d window writes: zero, even, odd, widest, and changes inside arrays",
		         window_writes);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sliding_median_filter_unit.f =====
sv/smf_pkg.sv
sv/smf_if.sv
sv/smf_cell.sv
sv/smf_sort_chain.sv
sv/sliding_median_filter_unit.sv
verif/tb.sv
